// File: rtl/htfd_pkg.sv
// ============================================================================
// htfd_pkg
// shared constants and controller/datapath interface types for the
// head/tail frame deframer
// ============================================================================
package htfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 32;
    localparam int FRAME_LEN = 10;
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] TAIL_RESET = 8'hBB;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_LEN);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_LEN - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTE = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // append the accepted byte
        logic shift;  // drop the front byte
        logic clear;  // empty the store
        logic emit;   // capture both payload words into the output register
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic             full;
        logic             empty;
        logic             head_at_front;
        logic             tail_at_end;
        logic             out_busy;
        logic [CNT_W-1:0] count;
    } t_dp_status;

endpackage

// File: rtl/head_tail_frame_deframer.sv
// ============================================================================
// head_tail_frame_deframer
// byte-serial deframer for fixed ten-byte head/payload/tail frames
// ============================================================================
// Bytes arrive one per transaction on the rx channel and are appended to a
// ten-byte frame store. A frame is a head byte, two 32-bit little-endian
// payload words and a tail byte. While the store is not full the input is
// not stalled. The byte that fills the store stalls the input for a check: if
// the store starts with the head byte and ends with the tail byte, both
// payload words go out as one output transaction (raw bits, no conversion)
// and the store is emptied. Otherwise the store drops its front byte and
// keeps dropping one byte per cycle until a head byte leads or it is empty,
// with the input stalled throughout. The output register holds a result
// while the consumer stalls; a new frame result waits in the check state
// only if the previous result has not yet been taken. head_byte (index 0)
// and tail_byte (index 1) are written through the cfg channel, which is
// always ready, and should only be changed while the block is idle.
// ============================================================================
module head_tail_frame_deframer
    import htfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input channel
    input  logic                 i_rx_valid,
    output logic                 o_rx_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    // frame result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [WORD_W-1:0]    o_payload_x,
    output logic [WORD_W-1:0]    o_payload_y,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    logic [BYTE_W-1:0] r_head_byte;
    logic [BYTE_W-1:0] r_tail_byte;
    t_dp_cmd           dp_cmd;
    t_dp_status        dp_status;

    // configuration registers, port is always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_byte <= HEAD_RESET;
            r_tail_byte <= TAIL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEAD_BYTE: r_head_byte <= i_cfg_data;
                CFG_TAIL_BYTE: r_tail_byte <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    htfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_rx_stall (o_rx_stall)
    );

    // frame store and output register
    htfd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_rx_byte   (i_rx_byte),
        .i_head_byte (r_head_byte),
        .i_tail_byte (r_tail_byte),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_payload_x (o_payload_x),
        .o_payload_y (o_payload_y)
    );

    // fill count never passes the frame length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_status.count <= CNT_FULL)
        else $error("fill count above frame length");

    // a result is only taken from a full, well-framed store
    a_emit_framed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit |-> (dp_status.full && dp_status.head_at_front
                         && dp_status.tail_at_end && !dp_status.out_busy))
        else $error("emit without a complete frame");

    // the byte that fills the store blocks further input
    a_fill_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.load && dp_status.count == CNT_LAST) |=> o_rx_stall)
        else $error("input not stalled after store filled");

    // an emitted frame shows up on the output next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit |=> o_out_valid)
        else $error("emitted frame not presented");

endmodule

// File: rtl/htfd_datapath.sv
// ============================================================================
// htfd_datapath
// ten-byte frame store with fill count, front/back byte compare and
// the registered result stage
// ============================================================================
module htfd_datapath
    import htfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic [BYTE_W-1:0] i_head_byte,
    input  logic [BYTE_W-1:0] i_tail_byte,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [WORD_W-1:0] o_payload_x,
    output logic [WORD_W-1:0] o_payload_y
);

    logic [BYTE_W-1:0] r_store [FRAME_LEN];
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_payload_x;
    logic [WORD_W-1:0] r_payload_y;

    // store contents, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_store[r_count[IDX_W-1:0]] <= i_rx_byte;
        end else if (i_cmd.shift) begin
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
                r_store[i] <= r_store[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.shift) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_payload_x <= {r_store[4], r_store[3], r_store[2], r_store[1]};
            r_payload_y <= {r_store[8], r_store[7], r_store[6], r_store[5]};
        end
    end

    always_comb begin
        o_status.full          = (r_count == CNT_FULL);
        o_status.empty         = (r_count == '0);
        o_status.head_at_front = (r_count != '0) && (r_store[0] == i_head_byte);
        o_status.tail_at_end   = (r_store[FRAME_LEN-1] == i_tail_byte);
        o_status.out_busy      = r_out_valid && i_out_stall;
        o_status.count         = r_count;
    end

    assign o_out_valid = r_out_valid;
    assign o_payload_x = r_payload_x;
    assign o_payload_y = r_payload_y;

endmodule

// File: rtl/htfd_ctrl.sv
// ============================================================================
// htfd_ctrl
// sequencer: fill the store, check a full store and emit it if framed, else
// drop bytes one at a time until a head byte leads or the store is empty
// ============================================================================
module htfd_ctrl
    import htfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_rx_stall
);

    typedef enum logic [1:0] {
        S_FILL,
        S_CHECK,
        S_SEEK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_rx_stall;
    logic   n_rx_stall;

    always_comb begin
        n_state    = r_state;
        n_rx_stall = r_rx_stall;
        o_cmd      = '0;
        unique case (r_state)
            S_FILL: begin
                o_cmd.load = i_rx_valid;
                if (i_rx_valid && (i_status.count == CNT_LAST)) begin
                    n_state    = S_CHECK;
                    n_rx_stall = 1'b1;
                end
            end
            S_CHECK: begin
                if (i_status.head_at_front && i_status.tail_at_end) begin
                    if (!i_status.out_busy) begin
                        o_cmd.emit  = 1'b1;
                        o_cmd.clear = 1'b1;
                        n_state     = S_FILL;
                        n_rx_stall  = 1'b0;
                    end
                end else begin
                    // front byte is either not a head or a head with a bad tail
                    o_cmd.shift = 1'b1;
                    n_state     = S_SEEK;
                end
            end
            S_SEEK: begin
                if (i_status.empty || i_status.head_at_front) begin
                    n_state    = S_FILL;
                    n_rx_stall = 1'b0;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            default: begin
                n_state    = S_FILL;
                n_rx_stall = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FILL;
            r_rx_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rx_stall <= n_rx_stall;
        end
    end

    assign o_rx_stall = r_rx_stall;

endmodule

// File: tb/tb_head_tail_frame_deframer.sv
// ============================================================================
// tb_head_tail_frame_deframer
// self-checking testbench for the head/tail frame deframer
// ============================================================================
// A short table of bytes goes first: a full store with no head byte, a frame
// whose tail does not match and that realigns onto a later head byte, and a
// frame built from all-zero and all-one payload bytes. Then several
// head/tail settings follow, each with random traffic that is mostly
// well-formed frames with random payload, mixed with broken tails, cut-short
// frames and noise. Every accepted byte runs through a local deframer model,
// and every frame result is checked against the oldest expected frame. The
// sender bursts and pauses, and the receiver stalls on a pattern of its own.
// ============================================================================
module tb_head_tail_frame_deframer
    import htfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = FRAME_LEN + 6;  // worst case realign plus margin
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 270;
    localparam int STALL_RUN_MAX  = 20;
    localparam int NUM_PHASES     = 7;
    localparam int NUM_ROWS       = 29;

    // one byte transaction, with an optional frame typed in by hand
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              typed;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
    } t_rx_item;

    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
    } t_frame;

    typedef struct {
        logic [BYTE_W-1:0] head;
        logic [BYTE_W-1:0] tail;
        int                gap_max;
        int                burst_max;
        int                stall_pct;
    } t_phase;

    // dut signals
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_rx_valid  = 1'b0;
    logic                 o_rx_stall;
    logic [BYTE_W-1:0]    i_rx_byte   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [WORD_W-1:0]    o_payload_x;
    logic [WORD_W-1:0]    o_payload_y;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BYTE_W-1:0]    i_cfg_data  = '0;

    // model state and configuration
    logic [BYTE_W-1:0] store_bytes [FRAME_LEN];
    int                store_fill = 0;
    logic [BYTE_W-1:0] head_cfg   = HEAD_RESET;
    logic [BYTE_W-1:0] tail_cfg   = TAIL_RESET;

    // stimulus and expected frames
    t_rx_item byte_q [$];
    t_rx_item rx_item = '0;
    t_frame   frame_q [$];

    // idling controls, set by the main sequence at the falling edge, and the sender and receiver counters
    int gap_max    = 3;
    int burst_max  = 6;
    int stall_pct  = 15;
    bit hold       = 1'b0;
    int gap_left   = 0;
    int burst_left = 1;
    int stall_left = 0;

    int mismatch_count = 0;
    int idle_cycles    = 0;

    head_tail_frame_deframer DUT (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("[%0t] mismatch: %s got %08h expected %08h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // drop stored bytes before the first head byte at or after start
    function automatic void drop_to_head(input int start);
        int pos;
        int i;
        pos = -1;
        for (i = start; i < store_fill; i++) begin
            if (pos < 0 && store_bytes[i] == head_cfg) pos = i;
        end
        if (pos < 0) begin
            store_fill = 0;
        end else if (pos > 0) begin
            for (i = 0; i < store_fill - pos; i++) store_bytes[i] = store_bytes[i + pos];
            store_fill = store_fill - pos;
        end
    endfunction

    // append one byte, resolve a full store, return a frame when one closes
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b,
                                        output t_frame frame);
        frame = '0;
        store_bytes[store_fill] = b;
        store_fill++;
        if (store_fill < FRAME_LEN) return 1'b0;
        drop_to_head(0);
        if (store_fill < FRAME_LEN) return 1'b0;
        if (store_bytes[FRAME_LEN-1] == tail_cfg) begin
            frame.x = {store_bytes[4], store_bytes[3], store_bytes[2], store_bytes[1]};
            frame.y = {store_bytes[8], store_bytes[7], store_bytes[6], store_bytes[5]};
            store_fill = 0;
            return 1'b1;
        end
        // bad tail: give up the leading head byte and look for the next one
        drop_to_head(1);
        return 1'b0;
    endfunction

    // sender: bursts of random length, random gaps, paused while hold is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else if (!i_rx_valid || !o_rx_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                i_rx_valid <= 1'b0;
            end else if (!hold && byte_q.size() > 0) begin
                rx_item    <= byte_q[0];
                i_rx_byte  <= byte_q[0].data;
                i_rx_valid <= 1'b1;
                void'(byte_q.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, burst_max);
                    gap_left   = $urandom_range(0, gap_max);
                end
            end else begin
                i_rx_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall runs of random length
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left  = $urandom_range(0, STALL_RUN_MAX);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // predict on each accepted byte, check each accepted frame
    always @(posedge i_clk) begin : monitor
        t_frame predicted;
        t_frame want;
        bit     got;
        if (i_rst_n) begin
            if (i_rx_valid && !o_rx_stall) begin
                got = deframe_byte(rx_item.data, predicted);
                if (rx_item.typed) frame_q.push_back({rx_item.x, rx_item.y});
                else if (got) frame_q.push_back(predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                if (frame_q.size() == 0) begin
                    report_mismatch("unexpected frame, payload_x", o_payload_x, '0);
                end else begin
                    want = frame_q.pop_front();
                    if (o_payload_x !== want.x) report_mismatch("payload_x", o_payload_x, want.x);
                    if (o_payload_y !== want.y) report_mismatch("payload_y", o_payload_y, want.y);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((i_rx_valid && !o_rx_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HEAD_BYTE) head_cfg <= data;
        else tail_cfg <= data;
    endtask

    function automatic void push_byte(input logic [BYTE_W-1:0] b);
        byte_q.push_back({b, 1'b0, {WORD_W{1'b0}}, {WORD_W{1'b0}}});
    endfunction

    // mostly good frames with random payload, plus broken ones and noise
    task automatic queue_random_traffic(input int n_bytes);
        int sent;
        int kind;
        int k;
        int i;
        sent = 0;
        while (sent < n_bytes) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                push_byte(head_cfg);
                for (i = 0; i < 8; i++) push_byte(8'($urandom_range(0, 255)));
                push_byte(tail_cfg);
                sent += 10;
            end else if (kind < 80) begin
                // bad tail
                push_byte(head_cfg);
                for (i = 0; i < 8; i++) push_byte(8'($urandom_range(0, 255)));
                push_byte(tail_cfg ^ 8'($urandom_range(1, 255)));
                sent += 10;
            end else if (kind < 90) begin
                // frame cut short
                k = $urandom_range(0, 7);
                push_byte(head_cfg);
                for (i = 0; i < k; i++) push_byte(8'($urandom_range(0, 255)));
                sent += k + 1;
            end else begin
                k = $urandom_range(1, 5);
                for (i = 0; i < k; i++) push_byte(8'($urandom_range(0, 255)));
                sent += k;
            end
        end
    endtask

    // wait until the block has nothing left in flight
    task automatic wait_quiet();
        @(negedge i_clk);
        while (byte_q.size() != 0 || i_rx_valid || frame_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // directed bytes under the reset head/tail values
    t_rx_item directed_rows [NUM_ROWS] = '{
        // full store with no head byte: all ten dropped
        '{8'h00, 1'b0, 32'h0, 32'h0}, '{8'hFF, 1'b0, 32'h0, 32'h0},
        '{8'h55, 1'b0, 32'h0, 32'h0}, '{8'h11, 1'b0, 32'h0, 32'h0},
        '{8'h22, 1'b0, 32'h0, 32'h0}, '{8'h33, 1'b0, 32'h0, 32'h0},
        '{8'h44, 1'b0, 32'h0, 32'h0}, '{8'h66, 1'b0, 32'h0, 32'h0},
        '{8'h77, 1'b0, 32'h0, 32'h0}, '{8'hBB, 1'b0, 32'h0, 32'h0},
        // tail mismatch, realigns onto the head byte in the last slot
        '{8'hAA, 1'b0, 32'h0, 32'h0}, '{8'h01, 1'b0, 32'h0, 32'h0},
        '{8'h02, 1'b0, 32'h0, 32'h0}, '{8'h03, 1'b0, 32'h0, 32'h0},
        '{8'h04, 1'b0, 32'h0, 32'h0}, '{8'h05, 1'b0, 32'h0, 32'h0},
        '{8'h06, 1'b0, 32'h0, 32'h0}, '{8'h07, 1'b0, 32'h0, 32'h0},
        '{8'h08, 1'b0, 32'h0, 32'h0}, '{8'hAA, 1'b0, 32'h0, 32'h0},
        // completes the realigned frame with all-zero and all-one words
        '{8'h00, 1'b0, 32'h0, 32'h0}, '{8'h00, 1'b0, 32'h0, 32'h0},
        '{8'h00, 1'b0, 32'h0, 32'h0}, '{8'h00, 1'b0, 32'h0, 32'h0},
        '{8'hFF, 1'b0, 32'h0, 32'h0}, '{8'hFF, 1'b0, 32'h0, 32'h0},
        '{8'hFF, 1'b0, 32'h0, 32'h0}, '{8'hFF, 1'b0, 32'h0, 32'h0},
        '{8'hBB, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF}
    };

    t_phase phases [NUM_PHASES] = '{
        '{8'hAA, 8'hBB, 0,  8,  0},   // reset values written back, no idling
        '{8'h00, 8'hFF, 4,  6,  20},
        '{8'hFF, 8'h00, 2,  12, 10},
        '{8'h5A, 8'h5A, 6,  4,  25},  // head equal to tail
        '{8'h00, 8'h00, 3,  8,  15},  // zero head, zero tail
        '{8'h00, 8'h00, 5,  5,  20},  // random values filled in below
        '{8'hAA, 8'hBB, 30, 3,  40}   // heavy idling on both sides
    };

    initial begin
        phases[5].head = 8'($urandom_range(0, 255));
        phases[5].tail = 8'($urandom_range(0, 255));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        @(negedge i_clk);
        for (int r = 0; r < NUM_ROWS; r++) byte_q.push_back(directed_rows[r]);
        wait_quiet();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_HEAD_BYTE, phases[p].head);
            write_reg(CFG_TAIL_BYTE, phases[p].tail);
            @(negedge i_clk);
            gap_max   = phases[p].gap_max;
            burst_max = phases[p].burst_max;
            stall_pct = phases[p].stall_pct;
            queue_random_traffic(PHASE_BYTES);

            // halfway through, hold the sender until every frame is out
            while (byte_q.size() > PHASE_BYTES / 2) @(negedge i_clk);
            hold = 1'b1;
            while (i_rx_valid || frame_q.size() != 0) @(negedge i_clk);
            hold = 1'b0;

            wait_quiet();
        end

        if (frame_q.size() != 0) begin
            report_mismatch("frames never seen, count", WORD_W'(frame_q.size()), '0);
        end
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
